>>> hw/rtl/mse_pkg.sv
// shared types and constants of the execute unit
`timescale 1ns / 1ps
`default_nettype none
package mse_pkg;
    localparam int MemBytes  = 65536;
    localparam int MemAw     = $clog2(MemBytes);
    localparam int ProgDepth = 4096;
    localparam int QDepth    = 2;

    localparam logic [3:0] ACT_ADD  = 4'd0;
    localparam logic [3:0] ACT_SUB  = 4'd1;
    localparam logic [3:0] ACT_MUL  = 4'd2;
    localparam logic [3:0] ACT_DIV  = 4'd3;
    localparam logic [3:0] ACT_SLT  = 4'd4;
    localparam logic [3:0] ACT_ADDI = 4'd5;
    localparam logic [3:0] ACT_SUBI = 4'd6;
    localparam logic [3:0] ACT_LW   = 4'd7;
    localparam logic [3:0] ACT_SW   = 4'd8;
    localparam logic [3:0] ACT_SLTI = 4'd9;
    localparam logic [3:0] ACT_BEQ  = 4'd10;
    localparam logic [3:0] ACT_BNE  = 4'd11;
    localparam logic [3:0] ACT_J    = 4'd12;

    typedef struct packed {
        logic [3:0]  action;
        logic [4:0]  dest_reg;
        logic [4:0]  src_reg;
        logic [4:0]  second_reg;
        logic [31:0] imm;
        logic [11:0] target;
    } t_instr;
endpackage
`default_nettype wire

>>> hw/rtl/mse_front.sv
// front end: accepts items into a short instruction queue
`timescale 1ns / 1ps
`default_nettype none
module mse_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  mse_pkg::t_instr     i_instr,
    output logic                o_q_valid,
    input  wire                 i_q_pop,
    output mse_pkg::t_instr     o_q_instr
);
    mse_pkg::t_instr r_q [mse_pkg::QDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push;

    assign o_ready   = (r_cnt != 2'(mse_pkg::QDepth));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_instr = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_instr;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/mse_divider.sv
// radix-2 signed divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module mse_divider (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [31:0] i_a,
    input  wire  [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_q
);
    logic [31:0] r_rem, r_quo, r_div;
    logic [5:0]  r_cnt;
    logic        r_busy, r_neg;
    logic [32:0] trial;

    assign trial = {r_rem[31:0], r_quo[31]} - {1'b0, r_div};
    assign o_q   = r_neg ? (32'd0 - r_quo) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; o_done <= 1'b0; r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_rem  <= '0;
                r_quo  <= i_a[31] ? (32'd0 - i_a) : i_a;
                r_div  <= i_b[31] ? (32'd0 - i_b) : i_b;
                r_neg  <= i_a[31] ^ i_b[31];
            end else if (r_busy) begin
                if (!trial[32]) r_rem <= trial[31:0];
                else r_rem <= {r_rem[30:0], r_quo[31]};
                r_quo <= {r_quo[30:0], ~trial[32]};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0; o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/mse_back.sv
// back end: register file, data memory, pc and the execute sequencer
`timescale 1ns / 1ps
`default_nettype none
module mse_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    output logic                o_q_pop,
    input  mse_pkg::t_instr     i_instr,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [11:0]         o_next_pc,
    output logic                o_reg_written,
    output logic [4:0]          o_written_reg,
    output logic [31:0]         o_written_value,
    output logic                o_divide_by_zero
);
    localparam logic [2:0] ST_CLR = 3'd0, ST_IDLE = 3'd1, ST_EXE = 3'd2,
                           ST_MEM = 3'd3, ST_DIV = 3'd4, ST_OUT = 3'd5,
                           ST_MUL = 3'd6;
    localparam int Aw = mse_pkg::MemAw;

    logic [31:0] r_rf [32];
    logic [7:0]  r_mem [mse_pkg::MemBytes];
    logic [2:0]  r_st;
    logic [11:0] r_pc;
    logic [Aw-1:0] r_clr;
    mse_pkg::t_instr r_ins;
    logic [31:0] r_a, r_b, r_addr, r_ld, r_prod;
    logic [1:0]  r_bi;
    logic [7:0]  r_rd;
    logic        r_first;
    logic [4:0]  r_wreg;
    logic [31:0] r_wval;
    logic        r_wr, r_dz;
    logic [11:0] r_npc;
    logic        div_start, div_done;
    logic [31:0] div_q;
    logic [11:0] seq_pc;
    logic [Aw-1:0] baddr;
    logic        dest_rt;

    mse_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_a(r_a), .i_b(r_b), .o_done(div_done), .o_q(div_q));

    assign o_q_pop   = (r_st == ST_IDLE) && i_q_valid;
    assign div_start = (r_st == ST_EXE) && (r_ins.action == mse_pkg::ACT_DIV)
                       && (r_b != 32'd0);
    assign seq_pc    = r_pc + 12'd1;
    assign baddr     = r_addr[Aw-1:0] + Aw'(r_bi);
    assign dest_rt   = (r_ins.action == mse_pkg::ACT_ADDI) ||
                       (r_ins.action == mse_pkg::ACT_SUBI) ||
                       (r_ins.action == mse_pkg::ACT_LW) ||
                       (r_ins.action == mse_pkg::ACT_SLTI);
    assign o_valid          = (r_st == ST_OUT);
    assign o_next_pc        = r_npc;
    assign o_reg_written    = r_wr;
    assign o_written_reg    = r_wreg;
    assign o_written_value  = r_wval;
    assign o_divide_by_zero = r_dz;

    // memory: one byte port, clear sweep after reset
    always_ff @(posedge i_clk) begin
        if (r_st == ST_CLR) r_mem[r_clr] <= 8'd0;
        else if (r_st == ST_MEM && r_ins.action == mse_pkg::ACT_SW && !r_first)
            r_mem[baddr] <= r_b[8*(3-r_bi) +: 8];
        r_rd <= r_mem[baddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 32; k++) r_rf[k] <= 32'd0;
        end else if (r_st == ST_OUT && i_ready && r_wr && r_wreg != 5'd0) begin
            r_rf[r_wreg] <= r_wval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLR; r_clr <= '0; r_pc <= '0;
        end else begin
            case (r_st)
                ST_CLR: begin
                    r_clr <= r_clr + Aw'(1);
                    if (r_clr == Aw'(mse_pkg::MemBytes - 1)) r_st <= ST_IDLE;
                end
                ST_IDLE: if (i_q_valid) begin
                    r_ins <= i_instr;
                    r_a   <= (i_instr.src_reg == 5'd0) ? 32'd0 : r_rf[i_instr.src_reg];
                    r_b   <= (i_instr.second_reg == 5'd0) ? 32'd0
                             : r_rf[i_instr.second_reg];
                    r_st  <= ST_EXE;
                end
                ST_EXE: begin
                    r_npc <= seq_pc;
                    r_wr  <= 1'b0; r_dz <= 1'b0; r_wval <= '0;
                    r_wreg <= dest_rt ? r_ins.second_reg : r_ins.dest_reg;
                    r_addr <= r_a + r_ins.imm;
                    r_bi <= 2'd0; r_first <= 1'b1;
                    r_st <= ST_OUT;
                    case (r_ins.action)
                        mse_pkg::ACT_ADD:  begin r_wr <= 1'b1; r_wval <= r_a + r_b; end
                        mse_pkg::ACT_SUB:  begin r_wr <= 1'b1; r_wval <= r_a - r_b; end
                        mse_pkg::ACT_MUL:  begin
                            r_prod <= r_a * r_b; r_st <= ST_MUL;
                        end
                        mse_pkg::ACT_DIV:  begin
                            r_wr <= 1'b1;
                            if (r_b == 32'd0) r_dz <= 1'b1;
                            else r_st <= ST_DIV;
                        end
                        mse_pkg::ACT_SLT:  begin
                            r_wr <= 1'b1; r_wval <= {31'd0, $signed(r_a) < $signed(r_b)};
                        end
                        mse_pkg::ACT_ADDI: begin r_wr <= 1'b1; r_wval <= r_a + r_ins.imm; end
                        mse_pkg::ACT_SUBI: begin r_wr <= 1'b1; r_wval <= r_a - r_ins.imm; end
                        mse_pkg::ACT_LW:   begin r_wr <= 1'b1; r_st <= ST_MEM; end
                        mse_pkg::ACT_SW:   r_st <= ST_MEM;
                        mse_pkg::ACT_SLTI: begin
                            r_wr <= 1'b1;
                            r_wval <= {31'd0, $signed(r_a) < $signed(r_ins.imm)};
                        end
                        mse_pkg::ACT_BEQ:  if (r_a == r_b) r_npc <= r_ins.target;
                        mse_pkg::ACT_BNE:  if (r_a != r_b) r_npc <= r_ins.target;
                        mse_pkg::ACT_J:    r_npc <= r_ins.target;
                        default: ;
                    endcase
                end
                ST_MUL: begin r_wr <= 1'b1; r_wval <= r_prod; r_st <= ST_OUT; end
                ST_DIV: if (div_done) begin r_wval <= div_q; r_st <= ST_OUT; end
                ST_MEM: begin
                    // r_rd is a registered read, so it holds the data for byte r_bi-1
                    r_first <= 1'b0;
                    if (!r_first) r_ld <= {r_ld[23:0], r_rd};
                    if (r_ins.action == mse_pkg::ACT_SW) begin
                        if (!r_first) begin
                            r_bi <= r_bi + 2'd1;
                            if (r_bi == 2'd3) r_st <= ST_OUT;
                        end
                    end else begin
                        if (!r_first) r_bi <= r_bi + 2'd1;
                        else r_bi <= 2'd1;
                        if (!r_first && r_bi == 2'd0) begin
                            r_wval <= {r_ld[23:0], r_rd}; r_st <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    if (r_wreg == 5'd0 && r_wr) begin
                        r_wr <= 1'b0; r_wval <= '0;
                    end
                    if (!r_wr) r_wreg <= 5'd0;
                    if (i_ready && (r_wr ? r_wreg != 5'd0 : r_wreg == 5'd0)) begin
                        r_pc <= r_npc; r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/mips_subset_execute_unit.sv
// top level: instruction queue in front of the execute back end
// path of an item: ST_IDLE, ST_EXE, then ST_MUL, ST_DIV or ST_MEM where needed, ST_OUT
// ST_OUT first drops a write to r0 or clears a no-write item's nonzero dest_reg
// throughput: one item at a time in the back end, popped in ST_IDLE; 2 queued
// reset: synchronous; afterwards the data memory is cleared one byte per cycle,
// all 65536 bytes, before the first item executes
`timescale 1ns / 1ps
`default_nettype none
module mips_subset_execute_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [3:0]  i_action,
    input  wire  [4:0]  i_dest_reg,
    input  wire  [4:0]  i_src_reg,
    input  wire  [4:0]  i_second_reg,
    input  wire  [31:0] i_immediate_value,
    input  wire  [11:0] i_branch_target,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [11:0] o_next_pc,
    output logic        o_reg_written,
    output logic [4:0]  o_written_reg,
    output logic [31:0] o_written_value,
    output logic        o_divide_by_zero
);
    mse_pkg::t_instr in_ins, q_ins;
    logic q_valid, q_pop, b_valid;

    assign in_ins = '{action: i_action, dest_reg: i_dest_reg, src_reg: i_src_reg,
                      second_reg: i_second_reg, imm: i_immediate_value,
                      target: i_branch_target};

    mse_front u_front (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .o_ready(o_ready), .i_instr(in_ins), .o_q_valid(q_valid), .i_q_pop(q_pop),
        .o_q_instr(q_ins));

    mse_back u_back (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid),
        .o_q_pop(q_pop), .i_instr(q_ins), .o_valid(b_valid), .i_ready(i_ready),
        .o_next_pc(o_next_pc), .o_reg_written(o_reg_written),
        .o_written_reg(o_written_reg), .o_written_value(o_written_value),
        .o_divide_by_zero(o_divide_by_zero));

    // hide the cleanup state where r0 writes are dropped or a no-write dest_reg is cleared
    assign o_valid = b_valid &&
        (o_reg_written ? (o_written_reg != 5'd0) : (o_written_reg == 5'd0));

    a_r0_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_reg_written && o_written_reg == 5'd0))
        else $error("r0 reported as written");
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_reg_written) |-> (o_written_value == 32'd0))
        else $error("value on no write");
    a_dz_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_written_value == 32'd0))
        else $error("divide by zero gave nonzero");
endmodule
`default_nettype wire

>>> bench/mips_subset_execute_unit_test.sv
// testbench for the mips subset execute unit: random and directed instructions
`timescale 1ns / 1ps
`default_nettype none

class exec_scoreboard;
    typedef struct packed {
        logic [11:0] next_pc;
        logic        reg_written;
        logic [4:0]  written_reg;
        logic [31:0] written_value;
        logic        divide_by_zero;
    } t_outcome;

    logic [31:0] regs [32];
    logic [7:0]  mem [int];
    logic [11:0] pc;
    t_outcome    pending [$];
    int          errors;

    function new();
        for (int k = 0; k < 32; k++) regs[k] = '0;
        pc = '0;
        errors = 0;
    endfunction

    function logic [7:0] mem_byte(logic [31:0] addr);
        int a;
        a = int'(addr % mse_pkg::MemBytes);
        return mem.exists(a) ? mem[a] : 8'h00;
    endfunction

    function void note_instr(mse_pkg::t_instr ins);
        logic [31:0] a, b, wval, ea;
        logic        wr, dz;
        logic [4:0]  wreg;
        logic [11:0] nxt;
        logic [31:0] ma, mb, q;
        t_outcome    o;
        a = regs[ins.src_reg];
        b = regs[ins.second_reg];
        nxt = 12'((pc + 13'd1) % mse_pkg::ProgDepth);
        wr = 1'b0; wreg = '0; wval = '0; dz = 1'b0;
        ea = a + ins.imm;
        case (ins.action)
            mse_pkg::ACT_ADD: begin wr = 1'b1; wreg = ins.dest_reg; wval = a + b; end
            mse_pkg::ACT_SUB: begin wr = 1'b1; wreg = ins.dest_reg; wval = a - b; end
            mse_pkg::ACT_MUL: begin wr = 1'b1; wreg = ins.dest_reg; wval = a * b; end
            mse_pkg::ACT_DIV: begin
                wr = 1'b1; wreg = ins.dest_reg;
                if (b == 32'd0) begin
                    dz = 1'b1;
                end else begin
                    ma = a[31] ? -a : a;
                    mb = b[31] ? -b : b;
                    q = ma / mb;
                    wval = (a[31] != b[31]) ? -q : q;
                end
            end
            mse_pkg::ACT_SLT: begin
                wr = 1'b1; wreg = ins.dest_reg; wval = {31'd0, $signed(a) < $signed(b)};
            end
            mse_pkg::ACT_ADDI: begin
                wr = 1'b1; wreg = ins.second_reg; wval = a + ins.imm;
            end
            mse_pkg::ACT_SUBI: begin
                wr = 1'b1; wreg = ins.second_reg; wval = a - ins.imm;
            end
            mse_pkg::ACT_LW: begin
                wr = 1'b1; wreg = ins.second_reg;
                wval = {mem_byte(ea), mem_byte(ea + 32'd1), mem_byte(ea + 32'd2),
                        mem_byte(ea + 32'd3)};
            end
            mse_pkg::ACT_SW: begin
                for (int k = 0; k < 4; k++)
                    mem[int'((ea + 32'(k)) % mse_pkg::MemBytes)] = b[31 - 8*k -: 8];
            end
            mse_pkg::ACT_SLTI: begin
                wr = 1'b1; wreg = ins.second_reg;
                wval = {31'd0, $signed(a) < $signed(ins.imm)};
            end
            mse_pkg::ACT_BEQ: if (a == b) nxt = 12'(ins.target % mse_pkg::ProgDepth);
            mse_pkg::ACT_BNE: if (a != b) nxt = 12'(ins.target % mse_pkg::ProgDepth);
            mse_pkg::ACT_J:   nxt = 12'(ins.target % mse_pkg::ProgDepth);
            default: ;
        endcase
        if (wr && wreg != 5'd0) begin
            regs[wreg] = wval;
        end else begin
            wr = 1'b0; wreg = 5'd0; wval = 32'd0;
        end
        pc = nxt;
        o.next_pc = nxt; o.reg_written = wr; o.written_reg = wreg;
        o.written_value = wval; o.divide_by_zero = dz;
        pending.push_back(o);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task check_result(t_outcome got);
        t_outcome want;
        if (pending.size() == 0) begin
            report("result with nothing pending", 32'(got.next_pc), 32'd0);
            return;
        end
        want = pending.pop_front();
        if (got.next_pc != want.next_pc)
            report("next_pc", 32'(got.next_pc), 32'(want.next_pc));
        if (got.reg_written != want.reg_written)
            report("reg_written", 32'(got.reg_written), 32'(want.reg_written));
        if (got.written_reg != want.written_reg)
            report("written_reg", 32'(got.written_reg), 32'(want.written_reg));
        if (got.written_value != want.written_value)
            report("written_value", got.written_value, want.written_value);
        if (got.divide_by_zero != want.divide_by_zero)
            report("divide_by_zero", 32'(got.divide_by_zero), 32'(want.divide_by_zero));
    endtask
endclass

module mips_subset_execute_unit_test;
    logic        i_clk, i_rst_n, i_valid, i_ready;
    logic [3:0]  i_action;
    logic [4:0]  i_dest_reg, i_src_reg, i_second_reg;
    logic [31:0] i_immediate_value;
    logic [11:0] i_branch_target;
    wire         o_ready, o_valid, o_reg_written, o_divide_by_zero;
    wire  [11:0] o_next_pc;
    wire  [4:0]  o_written_reg;
    wire  [31:0] o_written_value;

    exec_scoreboard sb;
    bit hold_off;
    int long_stall_at;

    mips_subset_execute_unit i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // valid stays high into the next item when there is no gap
    task automatic send_instr(mse_pkg::t_instr ins);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= ins.action; i_dest_reg <= ins.dest_reg;
        i_src_reg <= ins.src_reg; i_second_reg <= ins.second_reg;
        i_immediate_value <= ins.imm; i_branch_target <= ins.target;
        do @(posedge i_clk); while (!o_ready);
        sb.note_instr(ins);
        @(negedge i_clk);
    endtask

    function mse_pkg::t_instr make_instr(logic [3:0] act, logic [4:0] rd, logic [4:0] rs,
                                         logic [4:0] rt, logic [31:0] imm,
                                         logic [11:0] tgt);
        mse_pkg::t_instr ins;
        ins.action = act; ins.dest_reg = rd; ins.src_reg = rs;
        ins.second_reg = rt; ins.imm = imm; ins.target = tgt;
        return ins;
    endfunction

    // registers drawn mostly from a small set so values and addresses get reused
    function logic [4:0] pick_reg();
        return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 5));
    endfunction

    function logic [31:0] pick_imm();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($urandom_range(0, 64)) - 32'd32;
            3: return 32'hffff_fffc + 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    // receiver side: random stalls plus one long hold-off
    initial begin
        int g;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            g = gap_len();
            if (g > 0) begin
                i_ready <= 1'b0;
                repeat (g - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_next_pc, o_reg_written, o_written_reg,
                             o_written_value, o_divide_by_zero});
    end

    initial begin
        int cnt;
        sb = new();
        i_rst_n = 1'b0; i_valid = 1'b0;
        i_action = '0; i_dest_reg = '0; i_src_reg = '0; i_second_reg = '0;
        i_immediate_value = '0; i_branch_target = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed part
        send_instr(make_instr(mse_pkg::ACT_ADDI, 5'd0, 5'd0, 5'd1, 32'h7fffffff, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_ADDI, 5'd0, 5'd0, 5'd2, 32'h80000000, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_ADDI, 5'd0, 5'd0, 5'd3, 32'hffffffff, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_ADD, 5'd4, 5'd1, 5'd1, 32'd0, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_SUB, 5'd5, 5'd2, 5'd1, 32'd0, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_MUL, 5'd6, 5'd1, 5'd1, 32'd0, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_DIV, 5'd7, 5'd2, 5'd3, 32'd0, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_DIV, 5'd8, 5'd1, 5'd0, 32'd0, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_DIV, 5'd9, 5'd3, 5'd1, 32'd0, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_SLT, 5'd10, 5'd2, 5'd1, 32'd0, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_SLTI, 5'd0, 5'd1, 5'd11, 32'h80000000, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_SUBI, 5'd0, 5'd2, 5'd12, 32'h00000001, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_ADD, 5'd0, 5'd1, 5'd1, 32'd0, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_SW, 5'd0, 5'd0, 5'd1, 32'hfffffffe, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_LW, 5'd0, 5'd0, 5'd13, 32'hfffffffe, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_SW, 5'd0, 5'd3, 5'd2, 32'h00000001, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_LW, 5'd0, 5'd0, 5'd31, 32'h0000ffff, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_BEQ, 5'd0, 5'd1, 5'd1, 32'd0, 12'hfff));
        send_instr(make_instr(mse_pkg::ACT_BNE, 5'd0, 5'd1, 5'd1, 32'd0, 12'h123));
        send_instr(make_instr(mse_pkg::ACT_BNE, 5'd0, 5'd1, 5'd2, 32'd0, 12'h000));
        send_instr(make_instr(mse_pkg::ACT_J, 5'd0, 5'd0, 5'd0, 32'd0, 12'hffe));
        send_instr(make_instr(4'd13, 5'd31, 5'd31, 5'd31, 32'hffffffff, 12'hfff));
        send_instr(make_instr(4'd15, 5'd0, 5'd0, 5'd0, 32'd0, 12'd0));
        send_instr(make_instr(mse_pkg::ACT_J, 5'd0, 5'd0, 5'd0, 32'd0, 12'h000));
        // random part; one long receiver hold-off early on
        long_stall_at = $urandom_range(50, 300);
        cnt = 0;
        repeat (1750) begin
            if (cnt == long_stall_at) hold_off = 1'b1;
            send_instr(make_instr($urandom_range(0, 14) < 13 ? 4'($urandom_range(0, 12))
                                                               : 4'($urandom),
                                  pick_reg(), pick_reg(), pick_reg(), pick_imm(),
                                  12'($urandom)));
            cnt++;
        end
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0)
            $display("mips_subset_execute_unit verification clean");
        else
            $display("mips_subset_execute_unit verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("mips_subset_execute_unit verification failed");
        $finish;
    end
endmodule

`default_nettype wire
